@@ rtl/svme_pkg.sv @@
package svme_pkg;

  localparam int VECTOR_DEPTH = 256;
  localparam int INDEX_BITS   = 16;
  localparam int VALUE_BITS   = 32;
  localparam int RESULT_BITS  = 64;
  localparam int MAX_RESULTS  = 64;
  localparam int OP_BITS      = 2;
  localparam int MODE_BITS    = 2;

  localparam int ADDR_BITS  = $clog2(VECTOR_DEPTH);
  localparam int COUNT_BITS = $clog2(VECTOR_DEPTH + 1);
  localparam int RCNT_BITS  = $clog2(MAX_RESULTS + 1);
  localparam int ENTRY_BITS = INDEX_BITS + VALUE_BITS;

  // op codes of an input word; the fourth code is a no-op
  localparam logic [OP_BITS-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RUN         = 2'd2;

  // mode register bits: bit 1 selects dot product, bit 0 subtract
  localparam int MODE_SUB_BIT = 0;
  localparam int MODE_DOT_BIT = 1;

  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic [INDEX_BITS-1:0]        entry_index;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic [INDEX_BITS-1:0]        vector_max_index;
  } in_word_t;

  typedef struct packed {
    logic                          has_entry;
    logic [INDEX_BITS-1:0]         result_index;
    logic signed [RESULT_BITS-1:0] result_value;
    logic [INDEX_BITS-1:0]         result_max_index;
    logic                          is_last;
  } out_word_t;

  typedef struct packed {
    logic ld_first;
    logic ld_second;
    logic run_begin;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic dot_mode;
  } sts_t;

endpackage

@@ rtl/svme_ram.sv @@
module svme_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/svme_ctrl.sv @@
module svme_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [svme_pkg::OP_BITS-1:0]  op,
  input  svme_pkg::sts_t                sts,
  output svme_pkg::cmd_t                cmd,
  output logic                          busy
);

  import svme_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_LOAD_FIRST:  cmd.ld_first = 1'b1;
            OP_LOAD_SECOND: cmd.ld_second = 1'b1;
            OP_RUN: begin
              cmd.run_begin = 1'b1;
              state_nxt     = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (sts.walk_end) begin
          state_nxt = sts.dot_mode ? S_DRAIN : S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      // lets the last product reach the accumulator before the final word
      S_DRAIN: state_nxt = S_FINISH;
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ rtl/svme_dp.sv @@
module svme_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  svme_pkg::in_word_t             in_data,
  input  logic                           cfg_we,
  input  logic [svme_pkg::MODE_BITS-1:0] cfg_data,
  input  svme_pkg::cmd_t                 cmd,
  output svme_pkg::sts_t                 sts,
  output logic                           out_valid,
  output svme_pkg::out_word_t            out_data
);

  import svme_pkg::*;

  logic [MODE_BITS-1:0]  mode_r;
  logic [COUNT_BITS-1:0] cnt1_r, cnt2_r, cnt1_nxt, cnt2_nxt;
  logic [COUNT_BITS-1:0] ptr1_r, ptr2_r, ptr1_nxt, ptr2_nxt;
  logic [INDEX_BITS-1:0] max1_r, max2_r, max_idx;
  logic                  we1, we2;
  logic [ENTRY_BITS-1:0] wdata, rd1, rd2;

  logic [INDEX_BITS-1:0]        a_idx, b_idx, res_idx;
  logic signed [VALUE_BITS-1:0] a_val, b_val, sat_val;
  logic signed [VALUE_BITS+1:0] op1, op2, opb, sum;
  logic avail1, avail2, a_lt, a_gt, take1, take2, produce, dot, sub;

  logic                          pend_v_r;
  logic [INDEX_BITS-1:0]         pend_idx_r;
  logic signed [VALUE_BITS-1:0]  pend_val_r;
  logic [RCNT_BITS-1:0]          res_cnt_r;
  logic                          mul_v_r;
  logic signed [RESULT_BITS-1:0] mul_r, acc_r;
  logic signed [RESULT_BITS:0]   acc_sum;
  logic signed [RESULT_BITS-1:0] acc_sat;
  logic                          out_valid_r;
  out_word_t                     out_data_r;

  assign dot = mode_r[MODE_DOT_BIT];
  assign sub = mode_r[MODE_SUB_BIT];

  // stores: one entry per load, written at the fill count
  assign wdata = {in_data.entry_index, in_data.entry_value};
  assign we1   = cmd.ld_first  && (cnt1_r != COUNT_BITS'(VECTOR_DEPTH));
  assign we2   = cmd.ld_second && (cnt2_r != COUNT_BITS'(VECTOR_DEPTH));

  svme_ram #(.WIDTH(ENTRY_BITS), .DEPTH(VECTOR_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (cnt1_r[ADDR_BITS-1:0]),
    .wdata (wdata),
    .raddr (ptr1_nxt[ADDR_BITS-1:0]),
    .rdata (rd1)
  );

  svme_ram #(.WIDTH(ENTRY_BITS), .DEPTH(VECTOR_DEPTH)) u_ram2 (
    .clk   (clk),
    .we    (we2),
    .waddr (cnt2_r[ADDR_BITS-1:0]),
    .wdata (wdata),
    .raddr (ptr2_nxt[ADDR_BITS-1:0]),
    .rdata (rd2)
  );

  assign a_idx = rd1[ENTRY_BITS-1 -: INDEX_BITS];
  assign b_idx = rd2[ENTRY_BITS-1 -: INDEX_BITS];
  assign a_val = rd1[VALUE_BITS-1:0];
  assign b_val = rd2[VALUE_BITS-1:0];

  // merge step: pick side(s), add with negated second operand if subtracting
  always_comb begin
    avail1 = ptr1_r < cnt1_r;
    avail2 = ptr2_r < cnt2_r;
    a_lt   = a_idx < b_idx;
    a_gt   = a_idx > b_idx;
    take1  = avail1 && !(avail2 && a_gt);
    take2  = avail2 && !(avail1 && a_lt);
    opb    = (VALUE_BITS+2)'(b_val);
    op1    = take1 ? (VALUE_BITS+2)'(a_val) : '0;
    op2    = take2 ? (sub ? -opb : opb) : '0;
    sum    = op1 + op2;
    if (sum[VALUE_BITS+1:VALUE_BITS-1] == '0 || sum[VALUE_BITS+1:VALUE_BITS-1] == '1) begin
      sat_val = sum[VALUE_BITS-1:0];
    end else if (sum[VALUE_BITS+1]) begin
      sat_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
    produce = !(take1 && take2) || (sat_val != '0);
    res_idx = take1 ? a_idx : b_idx;
  end

  // pointers rest at zero between runs
  always_comb begin
    ptr1_nxt = ptr1_r;
    ptr2_nxt = ptr2_r;
    if (cmd.run_begin || cmd.finish) begin
      ptr1_nxt = '0;
      ptr2_nxt = '0;
    end else if (cmd.step) begin
      ptr1_nxt = ptr1_r + COUNT_BITS'(take1);
      ptr2_nxt = ptr2_r + COUNT_BITS'(take2);
    end
  end

  always_comb begin
    cnt1_nxt = cnt1_r;
    cnt2_nxt = cnt2_r;
    if (cmd.finish) begin
      cnt1_nxt = '0;
      cnt2_nxt = '0;
    end else begin
      if (we1) cnt1_nxt = cnt1_r + COUNT_BITS'(1);
      if (we2) cnt2_nxt = cnt2_r + COUNT_BITS'(1);
    end
  end

  assign max_idx = (max1_r > max2_r) ? max1_r : max2_r;

  assign sts.dot_mode = dot;
  assign sts.walk_end = dot ? (!avail1 || !avail2)
                            : ((res_cnt_r == RCNT_BITS'(MAX_RESULTS)) || (!avail1 && !avail2));

  // saturating Q32.32 accumulate
  always_comb begin
    acc_sum = {acc_r[RESULT_BITS-1], acc_r} + {mul_r[RESULT_BITS-1], mul_r};
    if (acc_sum[RESULT_BITS] != acc_sum[RESULT_BITS-1]) begin
      acc_sat = acc_sum[RESULT_BITS] ? {1'b1, {(RESULT_BITS-1){1'b0}}}
                                     : {1'b0, {(RESULT_BITS-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[RESULT_BITS-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ptr1_r      <= '0;
      ptr2_r      <= '0;
      max1_r      <= '0;
      max2_r      <= '0;
      pend_v_r    <= 1'b0;
      res_cnt_r   <= '0;
      mul_v_r     <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_data;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      ptr1_r      <= ptr1_nxt;
      ptr2_r      <= ptr2_nxt;
      // a new merge entry pushes out the held one; finish sends the last
      out_valid_r <= cmd.finish || (cmd.step && !dot && produce && pend_v_r);
      mul_v_r     <= cmd.step && dot && !a_lt && !a_gt;
      if (cmd.ld_first)  max1_r <= in_data.vector_max_index;
      if (cmd.ld_second) max2_r <= in_data.vector_max_index;
      if (cmd.run_begin) begin
        pend_v_r  <= 1'b0;
        res_cnt_r <= '0;
        acc_r     <= '0;
      end else if (mul_v_r) begin
        acc_r <= acc_sat;
      end
      if (cmd.step && !dot && produce) begin
        pend_v_r    <= 1'b1;
        res_cnt_r   <= res_cnt_r + RCNT_BITS'(1);
      end
      if (cmd.finish) begin
        pend_v_r    <= 1'b0;
        max1_r      <= '0;
        max2_r      <= '0;
        acc_r       <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mul_r <= RESULT_BITS'(a_val * b_val);
    if (cmd.step && !dot && produce) begin
      pend_idx_r <= res_idx;
      pend_val_r <= sat_val;
      out_data_r.has_entry        <= 1'b1;
      out_data_r.result_index     <= pend_idx_r;
      out_data_r.result_value     <= RESULT_BITS'(pend_val_r);
      out_data_r.result_max_index <= max_idx;
      out_data_r.is_last          <= 1'b0;
    end
    if (cmd.finish) begin
      out_data_r.result_max_index <= max_idx;
      out_data_r.is_last          <= 1'b1;
      if (dot) begin
        out_data_r.has_entry    <= 1'b1;
        out_data_r.result_index <= '0;
        out_data_r.result_value <= acc_r;
      end else begin
        out_data_r.has_entry    <= pend_v_r;
        out_data_r.result_index <= pend_v_r ? pend_idx_r : '0;
        out_data_r.result_value <= pend_v_r ? RESULT_BITS'(pend_val_r) : '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && out_data_r.is_last)
    else $error("finish did not emit a last word");

  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RCNT_BITS'(MAX_RESULTS))
    else $error("result count overran");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr1_r <= cnt1_r && ptr2_r <= cnt2_r)
    else $error("walk pointer beyond fill count");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.has_entry |-> out_data_r.is_last && out_data_r.result_value == '0)
    else $error("empty marker malformed");

  a_cleared_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> cnt1_r == '0 && cnt2_r == '0 && max1_r == '0 && max2_r == '0)
    else $error("run did not clear vectors");

endmodule

@@ rtl/sparse_vector_merge_engine.sv @@
// Sparse vector merge engine: loads two sorted (index, value) lists, then merges
// (add / subtract) or forms a saturated Q32.32 dot product.
// A new word is accepted every cycle while idle; a load into a full list is dropped.
// A run walks the lists one merge step at a time (one store read per side per step);
// a dot run then passes a drain state before the final word; busy is high throughout.
// The final word leaves in the same cycle that busy drops; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties both lists and sets mode to add.
module sparse_vector_merge_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  svme_pkg::in_word_t             in_data,
  output logic                           out_valid,
  output svme_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [svme_pkg::MODE_BITS-1:0] cfg_data
);

  import svme_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // mode writes must be issued only while idle (the block itself does not enforce it), so the port never back-pressures
  assign cfg_ready = 1'b1;

  // sequencer: idle/load, walk, product drain, final word
  svme_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // stores, walk pointers, merge adder, multiplier and accumulator, output word
  svme_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
